/* src/lrmr_pkg.sv */
// ----------------------------------------------------------------------------
// lrmr_pkg
// shared types and character codes of the lcd row message rotator
// ----------------------------------------------------------------------------
package lrmr_pkg;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_CHAR = 1'b1;

    localparam logic KIND_CURSOR = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [5:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } div_rsp_t;

endpackage

/* src/lrmr_div.sv */
// ----------------------------------------------------------------------------
// lrmr_div
// restoring divider, one quotient bit per cycle, for the part reload split
// ----------------------------------------------------------------------------
module lrmr_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  lrmr_pkg::div_req_t req,
    output lrmr_pkg::div_rsp_t rsp
);

    logic       busy_reg;
    logic       done_reg;
    logic [2:0] cnt_reg;
    logic [7:0] quo_reg;
    logic [5:0] rem_reg;
    logic [5:0] dvs_reg;
    logic [6:0] trial;
    logic [6:0] diff;
    logic       ge;

    assign trial = {rem_reg, quo_reg[7]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[5:0] : trial[5:0];
            quo_reg <= {quo_reg[6:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* src/lcd_row_message_rotator.sv */
// ----------------------------------------------------------------------------
// lcd_row_message_rotator
// two-row lcd message manager with static, temporary and rotating messages
// ----------------------------------------------------------------------------
// input items on s_*: tuser 0 is a service tick, tuser 1 a message character;
// tlast marks the final character of a message. results on m_* are cursor
// sets (tuser 0) and character writes (tuser 1), tlast on the final result
// of each input item. items are taken one at a time, s_tready only when idle.
// a character that does not end a message is only buffered. ending a message
// compares the stored text with the new one and copies it when they differ,
// scans the stored text for parts, runs the divider for a temporary message,
// then writes each shown character and pads the row with spaces.
// a tick steps the row timers and runs a display pass per row that changes.
// all stored text lives in one 128 entry memory with a registered read, so the
// walks above set the time. reset clears the store through per-entry valid
// bits at once, so the block is ready as soon as reset ends. one
// result waits in a holding stage and one in the output register; while the
// receiver stalls the sequencer waits.
// ----------------------------------------------------------------------------
module lcd_row_message_rotator
#(
    parameter int ROWS    = 2,
    parameter int COLS    = 16,
    parameter int MAX_LEN = 31
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row, timeout[7:0], msg_char[7:0], zero pad
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_row, out_char[7:0], zero pad
    output logic        m_tuser,   // out_kind
    output logic        m_tlast
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHAR   = 5'd1;
    localparam logic [4:0] S_CMP_RD = 5'd2;
    localparam logic [4:0] S_CMP_CK = 5'd3;
    localparam logic [4:0] S_CP_RD  = 5'd4;
    localparam logic [4:0] S_CP_WR  = 5'd5;
    localparam logic [4:0] S_CP_Z   = 5'd6;
    localparam logic [4:0] S_ST_RD  = 5'd7;
    localparam logic [4:0] S_ST_CK  = 5'd8;
    localparam logic [4:0] S_RELOAD = 5'd9;
    localparam logic [4:0] S_DIV    = 5'd10;
    localparam logic [4:0] S_SH_P   = 5'd11;
    localparam logic [4:0] S_SH_PC  = 5'd12;
    localparam logic [4:0] S_SH_RD  = 5'd13;
    localparam logic [4:0] S_SH_CK  = 5'd14;
    localparam logic [4:0] S_PAD    = 5'd15;
    localparam logic [4:0] S_TICK   = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    logic [4:0]   state_reg;
    logic [7:0]   period_reg;

    logic         cmd_reg;
    logic         row_reg;
    logic [7:0]   timeout_reg;
    logic [7:0]   char_reg;
    logic         last_reg;

    logic [4:0]   cnt_reg;
    logic         ended_reg;

    logic         cur_row_reg;
    logic         kind_reg;
    logic [4:0]   idx_reg;
    logic         diff_reg;
    logic [4:0]   nparts_reg;
    logic         sbuf_reg;
    logic [5:0]   ptr_reg;
    logic [5:0]   len_reg;
    logic         term_nl_reg;

    logic [5:0]   showpos_reg [2];
    logic [7:0]   ttimer_reg  [2];
    logic [7:0]   ptimer_reg  [2];
    logic [7:0]   preload_reg [2];

    logic         pend_valid_reg;
    logic         pend_kind_reg;
    logic         pend_row_reg;
    logic [7:0]   pend_char_reg;
    logic         m_valid_reg;
    logic         m_kind_reg;
    logic         m_row_reg;
    logic [7:0]   m_char_reg;
    logic         m_last_reg;

    logic [7:0]   store_mem [128];
    logic [127:0] store_vld_reg;
    logic [7:0]   st_rdata_reg;
    logic         st_rvld_reg;
    logic         st_we;
    logic [6:0]   st_waddr;
    logic [7:0]   st_wdata;
    logic [6:0]   st_raddr;
    logic [7:0]   st_rd;

    logic [7:0]   buf_mem [32];
    logic [7:0]   buf_rdata_reg;
    logic         buf_we;
    logic [4:0]   buf_raddr;

    logic         emit_req;
    logic         emit_kind;
    logic [7:0]   emit_char;
    logic         emit_ok;
    logic         out_free;

    logic         accept;
    logic         row_ok;
    logic         cur_ok;
    logic [5:0]   idx_next;
    logic [4:0]   nparts_next;

    lrmr_pkg::div_req_t div_req;
    lrmr_pkg::div_rsp_t div_rsp;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign row_ok   = 32'(row_reg) < 32'(ROWS);
    assign cur_ok   = 32'(cur_row_reg) < 32'(ROWS);
    assign st_rd    = st_rvld_reg ? st_rdata_reg : lrmr_pkg::CH_NUL;
    assign out_free = !m_valid_reg || m_tready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign idx_next = ptr_reg + {5'd0, term_nl_reg};
    assign nparts_next = nparts_reg + {4'd0, st_rd == lrmr_pkg::CH_NL};

    assign buf_we = (state_reg == S_CHAR) && !ended_reg && (char_reg != lrmr_pkg::CH_NUL)
                    && (32'(cnt_reg) < 32'(MAX_LEN));

    always_comb
    begin
        st_we     = 1'b0;
        st_waddr  = {cur_row_reg, kind_reg, idx_reg};
        st_wdata  = buf_rdata_reg;
        st_raddr  = '0;
        buf_raddr = idx_reg;
        emit_req  = 1'b0;
        emit_kind = lrmr_pkg::KIND_CHAR;
        emit_char = st_rd;
        case (state_reg)
            S_CMP_RD: st_raddr = {cur_row_reg, kind_reg, idx_reg};
            S_CP_WR:  st_we = 1'b1;
            S_CP_Z:
            begin
                st_we    = 1'b1;
                st_waddr = {cur_row_reg, kind_reg, cnt_reg};
                st_wdata = lrmr_pkg::CH_NUL;
            end
            S_ST_RD:  st_raddr = {cur_row_reg, kind_reg, idx_reg};
            S_SH_P:   st_raddr = {cur_row_reg, showpos_reg[cur_row_reg]};
            S_SH_PC:
            begin
                st_raddr  = {cur_row_reg, showpos_reg[cur_row_reg]};
                emit_req  = 1'b1;
                emit_kind = lrmr_pkg::KIND_CURSOR;
                emit_char = lrmr_pkg::CH_NUL;
            end
            S_SH_RD:  st_raddr = {cur_row_reg, sbuf_reg, ptr_reg[4:0]};
            S_SH_CK:
            begin
                st_raddr = {cur_row_reg, sbuf_reg, ptr_reg[4:0]};
                emit_req = (st_rd != lrmr_pkg::CH_NUL) && (st_rd != lrmr_pkg::CH_NL);
            end
            S_PAD:
            begin
                emit_req  = 32'(len_reg) < 32'(COLS);
                emit_char = lrmr_pkg::CH_SP;
            end
            default: ;
        endcase
    end

    assign div_req.start    = (state_reg == S_RELOAD) && (nparts_reg != 5'd0) && kind_reg;
    assign div_req.dividend = ttimer_reg[cur_row_reg];
    assign div_req.divisor  = {1'b0, nparts_reg} + 6'd1;

    lrmr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        st_rdata_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_vld_reg <= '0;
            st_rvld_reg   <= 1'b0;
        end
        else
        begin
            if (st_we)
            begin
                store_vld_reg[st_waddr] <= 1'b1;
            end
            st_rvld_reg <= store_vld_reg[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[cnt_reg] <= char_reg;
        end
        buf_rdata_reg <= buf_mem[buf_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 8'd10;
        end
        else if (cfg_wr_en)
        begin
            period_reg <= cfg_wr_data;
        end
    end

    // holding stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else if (emit_req && emit_ok)
        begin
            pend_valid_reg <= 1'b1;
            if (pend_valid_reg)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
        else if ((state_reg == S_DONE) && pend_valid_reg && out_free)
        begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_req && emit_ok)
        begin
            pend_kind_reg <= emit_kind;
            pend_row_reg  <= cur_row_reg;
            pend_char_reg <= emit_char;
            if (pend_valid_reg)
            begin
                m_kind_reg <= pend_kind_reg;
                m_row_reg  <= pend_row_reg;
                m_char_reg <= pend_char_reg;
                m_last_reg <= 1'b0;
            end
        end
        else if ((state_reg == S_DONE) && pend_valid_reg && out_free)
        begin
            m_kind_reg <= pend_kind_reg;
            m_row_reg  <= pend_row_reg;
            m_char_reg <= pend_char_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_char_reg, m_row_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= s_tuser;
            row_reg     <= s_tdata[0];
            timeout_reg <= s_tdata[8:1];
            char_reg    <= s_tdata[16:9];
            last_reg    <= s_tlast;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ended_reg      <= 1'b0;
            cur_row_reg    <= 1'b0;
            kind_reg       <= 1'b0;
            idx_reg        <= '0;
            diff_reg       <= 1'b0;
            nparts_reg     <= '0;
            sbuf_reg       <= 1'b0;
            ptr_reg        <= '0;
            len_reg        <= '0;
            term_nl_reg    <= 1'b0;
            for (int r = 0; r < 2; r++)
            begin
                showpos_reg[r] <= '0;
                ttimer_reg[r]  <= '0;
                ptimer_reg[r]  <= '0;
                preload_reg[r] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_row_reg <= 1'b0;
                        state_reg   <= (s_tuser == lrmr_pkg::CMD_TICK) ? S_TICK : S_CHAR;
                    end
                end
                S_CHAR:
                begin
                    if (!ended_reg && (char_reg == lrmr_pkg::CH_NUL))
                    begin
                        ended_reg <= 1'b1;
                    end
                    if (buf_we)
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                    if (last_reg && row_ok)
                    begin
                        ttimer_reg[row_reg] <= timeout_reg;
                        kind_reg    <= timeout_reg != 8'd0;
                        cur_row_reg <= row_reg;
                        idx_reg     <= '0;
                        diff_reg    <= 1'b0;
                        state_reg   <= S_CMP_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_CMP_RD: state_reg <= S_CMP_CK;
                S_CMP_CK:
                begin
                    if (idx_reg < cnt_reg)
                    begin
                        diff_reg  <= diff_reg | (st_rd != buf_rdata_reg);
                        idx_reg   <= idx_reg + 5'd1;
                        state_reg <= S_CMP_RD;
                    end
                    else if (diff_reg || (st_rd != lrmr_pkg::CH_NUL))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CP_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_CP_RD: state_reg <= (idx_reg < cnt_reg) ? S_CP_WR : S_CP_Z;
                S_CP_WR:
                begin
                    idx_reg   <= idx_reg + 5'd1;
                    state_reg <= S_CP_RD;
                end
                S_CP_Z:
                begin
                    showpos_reg[cur_row_reg] <= {kind_reg, 5'd0};
                    idx_reg    <= '0;
                    nparts_reg <= '0;
                    state_reg  <= S_ST_RD;
                end
                S_ST_RD: state_reg <= S_ST_CK;
                S_ST_CK:
                begin
                    if (st_rd == lrmr_pkg::CH_NUL)
                    begin
                        state_reg <= S_RELOAD;
                    end
                    else
                    begin
                        nparts_reg <= nparts_next;
                        if (idx_reg == 5'd31)
                        begin
                            state_reg <= S_RELOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 5'd1;
                            state_reg <= S_ST_RD;
                        end
                    end
                end
                S_RELOAD:
                begin
                    if (nparts_reg == 5'd0)
                    begin
                        preload_reg[cur_row_reg] <= '0;
                        ptimer_reg[cur_row_reg]  <= '0;
                        state_reg <= S_SH_P;
                    end
                    else if (kind_reg)
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        preload_reg[cur_row_reg] <= period_reg;
                        ptimer_reg[cur_row_reg]  <= period_reg;
                        state_reg <= S_SH_P;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        preload_reg[cur_row_reg] <= div_rsp.quotient;
                        ptimer_reg[cur_row_reg]  <= div_rsp.quotient;
                        state_reg <= S_SH_P;
                    end
                end
                S_SH_P: state_reg <= S_SH_PC;
                S_SH_PC:
                begin
                    if (emit_ok)
                    begin
                        if (st_rd == lrmr_pkg::CH_NUL)
                        begin
                            sbuf_reg <= ttimer_reg[cur_row_reg] != 8'd0;
                            ptr_reg  <= '0;
                        end
                        else
                        begin
                            sbuf_reg <= showpos_reg[cur_row_reg][5];
                            ptr_reg  <= {1'b0, showpos_reg[cur_row_reg][4:0]};
                        end
                        len_reg   <= '0;
                        state_reg <= S_SH_RD;
                    end
                end
                S_SH_RD: state_reg <= S_SH_CK;
                S_SH_CK:
                begin
                    if ((st_rd == lrmr_pkg::CH_NUL) || (st_rd == lrmr_pkg::CH_NL))
                    begin
                        term_nl_reg <= st_rd == lrmr_pkg::CH_NL;
                        state_reg   <= S_PAD;
                    end
                    else if (emit_ok)
                    begin
                        len_reg <= len_reg + 6'd1;
                        ptr_reg <= ptr_reg + 6'd1;
                        if (ptr_reg == 6'd31)
                        begin
                            term_nl_reg <= 1'b0;
                            state_reg   <= S_PAD;
                        end
                        else
                        begin
                            state_reg <= S_SH_RD;
                        end
                    end
                end
                S_PAD:
                begin
                    if (emit_req)
                    begin
                        if (emit_ok)
                        begin
                            len_reg <= len_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        showpos_reg[cur_row_reg] <= {sbuf_reg, idx_next[4:0]};
                        if ((cmd_reg == lrmr_pkg::CMD_TICK) && !cur_row_reg)
                        begin
                            cur_row_reg <= 1'b1;
                            state_reg   <= S_TICK;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_TICK:
                begin
                    if (!cur_ok)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        if (ttimer_reg[cur_row_reg] != 8'd0)
                        begin
                            ttimer_reg[cur_row_reg] <= ttimer_reg[cur_row_reg] - 8'd1;
                        end
                        if (ttimer_reg[cur_row_reg] == 8'd1)
                        begin
                            // temporary message expired, back to the static one
                            kind_reg   <= 1'b0;
                            showpos_reg[cur_row_reg] <= '0;
                            idx_reg    <= '0;
                            nparts_reg <= '0;
                            state_reg  <= S_ST_RD;
                        end
                        else if (ptimer_reg[cur_row_reg] == 8'd1)
                        begin
                            ptimer_reg[cur_row_reg] <= preload_reg[cur_row_reg];
                            state_reg <= S_SH_P;
                        end
                        else
                        begin
                            if (ptimer_reg[cur_row_reg] != 8'd0)
                            begin
                                ptimer_reg[cur_row_reg] <= ptimer_reg[cur_row_reg] - 8'd1;
                            end
                            if (!cur_row_reg)
                            begin
                                cur_row_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE:
                begin
                    if ((cmd_reg == lrmr_pkg::CMD_CHAR) && last_reg)
                    begin
                        cnt_reg   <= '0;
                        ended_reg <= 1'b0;
                    end
                    if (!pend_valid_reg || out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("result left in holding stage at idle");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_RD) |-> !ptr_reg[5])
        else $error("display pointer past end of buffer");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside of reload wait");

    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        buf_we |=> (32'(cnt_reg) <= 32'(MAX_LEN)))
        else $error("incoming count beyond maximum length");
`endif

endmodule
